/* hw/rtl/lrd_pkg.sv */
`default_nettype none

package lrd_pkg;

    // Header layout: lengths, level, bare flag, then eight stamp bytes
    localparam logic [3:0] HPOS_MSG_LEN = 4'd0;
    localparam logic [3:0] HPOS_SRC_LEN = 4'd1;
    localparam logic [3:0] HPOS_LEVEL   = 4'd2;
    localparam logic [3:0] HPOS_BARE    = 4'd3;
    localparam logic [3:0] HPOS_LAST    = 4'd11;

    localparam logic [7:0] BARE_TRUE       = 8'h01;
    localparam logic [7:0] MAX_LEVEL_RESET = 8'd4;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_MSG    = 2'd1,
        KIND_SRC    = 2'd2,
        KIND_ERROR  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  msg_len;
        logic [7:0]  src_len;
        logic [7:0]  level;
        logic        is_bare;
        logic [63:0] stamp;
        logic [7:0]  data_byte;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

/* hw/rtl/log_record_deframer_unit.sv */
// Log record deframer.
// Input channel: one raw byte per beat on i_in_byte, qualified by i_in_valid;
// the block drives o_in_stall. Records are back to back: 12 header bytes
// (message length, source length, level, bare flag, 8-byte big-endian stamp)
// followed by the message bytes and then the source bytes.
// Output channel: o_out_valid with o_kind, header fields, o_data_byte and
// o_last; the receiver drives i_out_stall. A header beat (or a level error
// when the level exceeds max_level) follows the last header byte; each payload
// byte yields one tagged beat. Payload of a rejected record is dropped.
// Config channel: i_cfg_valid/o_cfg_ready write max_level (reset value 4);
// write it only while the block is idle. It is sampled when a header ends.
// A result is registered in the output buffer before it shows on o_out_valid.
// Throughput: one input byte per cycle while o_in_stall is low, set by the
// single parse stage and the output register; a two-entry output buffer
// (output register plus skid entry) keeps input flowing while a result waits.
// Stall: o_in_stall rises only once both output entries are full.
// Reset (i_rst_n low, synchronous): parser returns to header byte 0, output
// buffer empties, max_level returns to 4.
`default_nettype none

module log_record_deframer_unit
    import lrd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_in_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_msg_len,
    output logic [7:0]       o_src_len,
    output logic [7:0]       o_level,
    output logic             o_is_bare,
    output logic [63:0]      o_stamp,
    output logic [7:0]       o_data_byte,
    output logic             o_last
);

    logic [7:0] r_max_level;
    logic       in_fire;
    logic       buf_full;
    logic       result_valid;
    t_result    result;
    t_result    out_beat;

    // config register: always ready, takes the write data as is
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_level <= MAX_LEVEL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_level <= i_cfg_data;
        end
    end

    // hold the input only when no room is left for another result
    assign o_in_stall = buf_full;
    assign in_fire    = i_in_valid & ~buf_full;

    lrd_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (in_fire),
        .i_in_byte      (i_in_byte),
        .i_max_level    (r_max_level),
        .o_result       (result),
        .o_result_valid (result_valid)
    );

    lrd_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (result_valid),
        .i_push_data (result),
        .o_full      (buf_full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (out_beat)
    );

    assign o_kind      = out_beat.kind;
    assign o_msg_len   = out_beat.msg_len;
    assign o_src_len   = out_beat.src_len;
    assign o_level     = out_beat.level;
    assign o_is_bare   = out_beat.is_bare;
    assign o_stamp     = out_beat.stamp;
    assign o_data_byte = out_beat.data_byte;
    assign o_last      = out_beat.last;

endmodule

`default_nettype wire

/* hw/rtl/lrd_parser.sv */
`default_nettype none

module lrd_parser
    import lrd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire logic [7:0] i_in_byte,
    input  wire logic [7:0] i_max_level,
    output t_result         o_result,
    output logic            o_result_valid
);

    logic [3:0]  r_header_pos, n_header_pos;
    logic [7:0]  r_msg_count,  n_msg_count;
    logic [7:0]  r_src_count,  n_src_count;
    logic [7:0]  r_level,      n_level;
    logic        r_bare,       n_bare;
    logic [63:0] r_stamp,      n_stamp;
    logic [8:0]  r_payload_left, n_payload_left;
    logic        r_dropping,   n_dropping;

    logic [8:0]  payload_dec;
    logic [8:0]  payload_total;
    logic        is_msg;

    assign payload_dec   = r_payload_left - 9'd1;
    assign is_msg        = r_payload_left > {1'b0, r_src_count};
    assign payload_total = {1'b0, n_msg_count} + {1'b0, n_src_count};

    always_comb begin
        n_header_pos   = r_header_pos;
        n_msg_count    = r_msg_count;
        n_src_count    = r_src_count;
        n_level        = r_level;
        n_bare         = r_bare;
        n_stamp        = r_stamp;
        n_payload_left = r_payload_left;
        n_dropping     = r_dropping;
        o_result_valid = 1'b0;
        o_result       = '0;

        if (r_payload_left != 9'd0) begin
            // payload beat: tag it, or drop it quietly for a rejected record
            n_payload_left = payload_dec;
            if (r_dropping) begin
                if (payload_dec == 9'd0) begin
                    n_dropping = 1'b0;
                end
            end else begin
                o_result_valid = 1'b1;
                o_result.kind  = is_msg ? KIND_MSG : KIND_SRC;
                o_result.data_byte = i_in_byte;
                o_result.last  = (payload_dec == 9'd0);
            end
        end else begin
            case (r_header_pos)
                HPOS_MSG_LEN: n_msg_count = i_in_byte;
                HPOS_SRC_LEN: n_src_count = i_in_byte;
                HPOS_LEVEL:   n_level     = i_in_byte;
                HPOS_BARE:    n_bare      = (i_in_byte == BARE_TRUE);
                default:      n_stamp     = {r_stamp[55:0], i_in_byte};
            endcase

            if (r_header_pos < HPOS_LAST) begin
                n_header_pos = r_header_pos + 4'd1;
            end else begin
                n_header_pos   = '0;
                n_payload_left = payload_total;
                o_result_valid = 1'b1;
                if (n_level > i_max_level) begin
                    n_dropping    = (payload_total != 9'd0);
                    o_result.kind = KIND_ERROR;
                    o_result.last = 1'b1;
                end else begin
                    n_dropping    = 1'b0;
                    o_result.kind = KIND_HEADER;
                    o_result.last = (payload_total == 9'd0);
                end
            end
        end

        // every result carries the record's header values
        o_result.msg_len = n_msg_count;
        o_result.src_len = n_src_count;
        o_result.level   = n_level;
        o_result.is_bare = n_bare;
        o_result.stamp   = n_stamp;
        o_result_valid   = o_result_valid & i_fire;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_pos   <= '0;
            r_msg_count    <= '0;
            r_src_count    <= '0;
            r_level        <= '0;
            r_bare         <= 1'b0;
            r_stamp        <= '0;
            r_payload_left <= '0;
            r_dropping     <= 1'b0;
        end else if (i_fire) begin
            r_header_pos   <= n_header_pos;
            r_msg_count    <= n_msg_count;
            r_src_count    <= n_src_count;
            r_level        <= n_level;
            r_bare         <= n_bare;
            r_stamp        <= n_stamp;
            r_payload_left <= n_payload_left;
            r_dropping     <= n_dropping;
        end
    end

    a_drop_needs_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dropping |-> (r_payload_left != 9'd0))
        else $error("dropping with no payload left");

    a_no_header_in_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_payload_left != 9'd0) |-> (r_header_pos == 4'd0))
        else $error("header position moved during payload");

    a_header_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_header_pos <= HPOS_LAST)
        else $error("header position out of range");

endmodule

`default_nettype wire

/* hw/rtl/lrd_out_buf.sv */
`default_nettype none

module lrd_out_buf
    import lrd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_push_data,
    output logic         o_full,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_result      o_out
);

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    pop;

    assign pop = r_out_valid & ~i_out_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = i_push;
                n_out       = i_push_data;
            end
        end else if (i_push) begin
            n_skid_valid = 1'b1;
            n_skid       = i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with output empty");

    a_no_push_into_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_push)
        else $error("result pushed while skid entry occupied");

    a_hold_while_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled output beat changed");

endmodule

`default_nettype wire
